// ===== rtl/obu_size_back_annotator_unit_macros.svh =====
// Assertion helpers for the size back-annotator, clocked on clk_i and held off in reset.
`ifndef OBU_SIZE_BACK_ANNOTATOR_UNIT_MACROS_SVH
`define OBU_SIZE_BACK_ANNOTATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define OBU_SBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OBU_SBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/obu_sba_pkg.sv =====
package obu_sba_pkg;

  localparam int WORD_W                = 32;
  localparam int GSB_W                 = 4;
  localparam int SIZE_FIELD_BYTES      = 4;
  localparam int TILE_SIZE_FIELD_BYTES = 4;
  localparam int CFG_IDX_W             = 1;
  localparam int CFG_DATA_W            = 1;
  localparam int QUEUE_DEPTH           = 2;
  localparam int QPTR_W                = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W                = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] LEB_MASK = 8'h7f;
  localparam logic [7:0] LEB_CONT = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 1'b0,
    CFG_FRAME_OBU = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_WRITTEN    = 1'b0,
    ST_INCOMPLETE = 1'b1
  } status_e;

  // One classified record handed from the front to the back.
  typedef struct packed {
    status_e             status;
    logic                frame_last;
    logic                frame_obu;
    logic                hdr_adj;
    logic [GSB_W-1:0]    gsb;
    logic [WORD_W-1:0]   write_offset;
    logic [WORD_W-1:0]   coded;
    logic [WORD_W-1:0]   hdr_span;
  } job_t;

  // Fixed-length LEB128: 7 payload bits per byte, continuation on all but the last byte.
  function automatic logic [WORD_W-1:0] leb_fixed(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] w;
    logic [7:0]        b;
    w = '0;
    for (int k = 0; k < SIZE_FIELD_BYTES; k++) begin
      b = 8'(v >> (7 * k)) & LEB_MASK;
      if (k != SIZE_FIELD_BYTES - 1) begin
        b = b | LEB_CONT;
      end
      w[8*k +: 8] = b;
    end
    return w;
  endfunction

endpackage

// ===== rtl/obu_sba_if.sv =====
interface obu_sba_tile_if;
  import obu_sba_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] tile_length;
  logic [WORD_W-1:0] tile_data_size;
  logic [GSB_W-1:0]  group_size_field_bytes;
  logic              first_in_group;
  logic              last_in_group;
  logic              last_in_frame;
  logic [WORD_W-1:0] frame_hdr_offset;

  modport source (
    output valid, tile_length, tile_data_size, group_size_field_bytes,
           first_in_group, last_in_group, last_in_frame, frame_hdr_offset,
    input  ready
  );
  modport sink (
    input  valid, tile_length, tile_data_size, group_size_field_bytes,
           first_in_group, last_in_group, last_in_frame, frame_hdr_offset,
    output ready
  );
endinterface

interface obu_sba_patch_if;
  import obu_sba_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [WORD_W-1:0] write_offset;
  logic [WORD_W-1:0] size_field;
  logic              frame_last;

  modport source (
    output valid, status, write_offset, size_field, frame_last,
    input  ready
  );
  modport sink (
    input  valid, status, write_offset, size_field, frame_last,
    output ready
  );
endinterface

// ===== rtl/obu_sba_front.sv =====
module obu_sba_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [obu_sba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [obu_sba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  obu_sba_tile_if.sink                       tile,
  output logic                               job_valid_o,
  input  logic                               job_ready_i,
  output obu_sba_pkg::job_t                  job_o
);
  import obu_sba_pkg::*;

  logic              enable_q, frame_obu_q;
  logic              in_frame_q, in_frame_d;
  logic              suppress_q, suppress_d;
  logic [WORD_W-1:0] wp_q, wp_d;
  logic [WORD_W-1:0] gp_q, gp_d;
  logic [WORD_W-1:0] span_q, span_d;

  logic              accept;
  logic [WORD_W-1:0] gsb_ext;
  logic [WORD_W-1:0] wp_first;
  logic [WORD_W-1:0] wp_eff;
  logic [WORD_W-1:0] span_eff;
  logic [WORD_W-1:0] gp_new;
  logic              zero_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      frame_obu_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:    enable_q    <= cfg_wdata_i[0];
        CFG_FRAME_OBU: frame_obu_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign tile.ready = job_ready_i;
  assign accept     = tile.valid && tile.ready;
  assign gsb_ext    = WORD_W'(tile.group_size_field_bytes);
  assign zero_len   = (tile.tile_length == '0);

  always_comb begin
    wp_first = tile.tile_length - tile.tile_data_size - gsb_ext - WORD_W'(SIZE_FIELD_BYTES);
    if (gsb_ext != '0 && !(tile.first_in_group && tile.last_in_group)) begin
      wp_first = wp_first - WORD_W'(TILE_SIZE_FIELD_BYTES);
    end
    if (in_frame_q) begin
      wp_eff   = wp_q;
      span_eff = span_q;
    end else begin
      wp_eff   = frame_obu_q ? tile.frame_hdr_offset : wp_first;
      span_eff = tile.tile_length - tile.tile_data_size;
    end
    if (tile.first_in_group) begin
      gp_new = tile.tile_data_size + gsb_ext
             + (tile.last_in_group ? '0 : WORD_W'(TILE_SIZE_FIELD_BYTES));
    end else begin
      gp_new = gp_q + tile.tile_length;
    end
  end

  // Emit on a zero-length record or a group end while enabled, unless the frame is silenced.
  assign job_valid_o = tile.valid && enable_q && !suppress_q
                     && (zero_len || tile.last_in_group);

  always_comb begin
    job_o              = '0;
    job_o.status       = zero_len ? ST_INCOMPLETE : ST_WRITTEN;
    job_o.frame_last   = zero_len || tile.last_in_frame;
    job_o.frame_obu    = frame_obu_q;
    job_o.hdr_adj      = (gsb_ext != '0) && !tile.first_in_group;
    job_o.gsb          = tile.group_size_field_bytes;
    job_o.write_offset = wp_eff;
    job_o.coded        = gp_new;
    job_o.hdr_span     = span_eff;
  end

  always_comb begin
    in_frame_d = in_frame_q;
    suppress_d = suppress_q;
    wp_d       = wp_q;
    gp_d       = gp_q;
    span_d     = span_q;
    if (accept && enable_q) begin
      if (!suppress_q) begin
        in_frame_d = 1'b1;
        span_d     = span_eff;
        wp_d       = wp_eff;
        if (zero_len) begin
          suppress_d = 1'b1;
        end else if (tile.last_in_group) begin
          wp_d = wp_eff + gp_new + WORD_W'(SIZE_FIELD_BYTES + 1);
          gp_d = '0;
        end else begin
          gp_d = gp_new;
        end
      end
      if (tile.last_in_frame) begin
        in_frame_d = 1'b0;
        suppress_d = 1'b0;
        wp_d       = '0;
        gp_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      suppress_q <= 1'b0;
      wp_q       <= '0;
      gp_q       <= '0;
      span_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      suppress_q <= suppress_d;
      wp_q       <= wp_d;
      gp_q       <= gp_d;
      span_q     <= span_d;
    end
  end

endmodule

// ===== rtl/obu_sba_queue.sv =====
module obu_sba_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  obu_sba_pkg::job_t push_job_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output obu_sba_pkg::job_t pop_job_o
);
  import obu_sba_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/obu_sba_back.sv =====
module obu_sba_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  obu_sba_pkg::job_t job_i,
  obu_sba_patch_if.source   patch
);
  import obu_sba_pkg::*;

  logic              out_valid_q;
  logic              status_q, status_d;
  logic              last_q, last_d;
  logic [WORD_W-1:0] offset_q, offset_d;
  logic [WORD_W-1:0] size_q, size_d;
  logic [WORD_W-1:0] payload;
  logic              pop;

  assign job_ready_o = !out_valid_q || patch.ready;
  assign pop         = job_valid_i && job_ready_o;

  always_comb begin
    payload = job_i.coded;
    if (job_i.frame_obu) begin
      // Add the derived frame-header size plus one.
      payload = job_i.coded + job_i.hdr_span - job_i.write_offset - WORD_W'(job_i.gsb)
              - WORD_W'(SIZE_FIELD_BYTES)
              - (job_i.hdr_adj ? WORD_W'(TILE_SIZE_FIELD_BYTES) : '0);
    end
    status_d = job_i.status;
    last_d   = job_i.frame_last;
    if (job_i.status == ST_INCOMPLETE) begin
      offset_d = '0;
      size_d   = '0;
    end else begin
      offset_d = job_i.write_offset;
      size_d   = leb_fixed(payload);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      status_q <= status_d;
      last_q   <= last_d;
      offset_q <= offset_d;
      size_q   <= size_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_ready_o) begin
      out_valid_q <= job_valid_i;
    end
  end

  assign patch.valid        = out_valid_q;
  assign patch.status       = status_q;
  assign patch.write_offset = offset_q;
  assign patch.size_field   = size_q;
  assign patch.frame_last   = last_q;

endmodule

// ===== rtl/obu_size_back_annotator_unit.sv =====
// Tile group size back-annotator. Feed one tile-size record per word on tile_i; for every
// tile group end the block returns on patch_o the byte offset of that group's OBU size field
// and the fixed four-byte LEB128 word to write there (payload bits above 27 dropped), with
// frame_last marking the frame's final result. A zero-length tile returns one status=1
// word and silences the frame until its last_in_frame record. With enable low, records
// are taken and dropped. Rate: one record per cycle, sustained unless patch_o stalls; the
// front updates the running write pointer and group sum of each record in the cycle it is
// accepted, and that single add chain sets the pace. A result goes via the two-entry
// queue and the output register to patch_o. The user must write config registers (index 0
// enable, index 1 frame_obu_mode) only while idle; the block does not enforce it.
`include "obu_size_back_annotator_unit_macros.svh"

module obu_size_back_annotator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [obu_sba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [obu_sba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  obu_sba_tile_if.sink                       tile_i,
  obu_sba_patch_if.source                    patch_o
);
  import obu_sba_pkg::*;

  // Front to queue.
  logic push_valid, push_ready;
  job_t push_job;
  // Queue to back.
  logic pop_valid, pop_ready;
  job_t pop_job;

  // Classify each record and advance frame state.
  obu_sba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tile        (tile_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  // Hold classified words so front and back stall independently.
  obu_sba_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Derive header size, encode LEB128 and register the result word.
  obu_sba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .patch       (patch_o)
  );

  // An incomplete-frame word carries no offset or size and always ends the frame.
  `OBU_SBA_ASSERT_NOW(a_incomplete_word, patch_o.valid && patch_o.status, patch_o.write_offset == '0 && patch_o.size_field == '0 && patch_o.frame_last, "incomplete word carries data")

  // A written size field has continuation on bytes 0..2 and none on byte 3.
  `OBU_SBA_ASSERT_NOW(a_leb_form, patch_o.valid && !patch_o.status, patch_o.size_field[7] && patch_o.size_field[15] && patch_o.size_field[23] && !patch_o.size_field[31], "malformed LEB128 word")

  // A word popped from the queue must show up on the output next cycle.
  `OBU_SBA_ASSERT_NEXT(a_pop_lands, pop_valid && pop_ready, patch_o.valid, "popped word lost")

  // An accepted record that produces a result must find room in the queue.
  `OBU_SBA_ASSERT_NOW(a_push_room, tile_i.valid && tile_i.ready && push_valid, push_ready, "result dropped at queue")

endmodule

// ===== tb/tb_obu_size_back_annotator_unit.sv =====
`timescale 1ns / 100ps

module tb_obu_size_back_annotator_unit;
  import obu_sba_pkg::*;

  // Give up well past the slowest legal run: every word held off by both sides.
  localparam int unsigned LIMIT_CYCLES = 400_000;
  // Idle time after the last expected word has left, before a config write.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_PRINTED = 40;
  localparam int N_DIRECTED = 22;

  // One tile-size record as the tile channel carries it.
  typedef struct packed {
    logic [WORD_W-1:0] tile_length;
    logic [WORD_W-1:0] tile_data_size;
    logic [GSB_W-1:0]  gsb;
    logic              grp_first;
    logic              grp_last;
    logic              frm_last;
    logic [WORD_W-1:0] frame_hdr_offset;
  } tile_rec_t;

  // One patch word as the patch channel carries it.
  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] write_offset;
    logic [WORD_W-1:0] size_field;
    logic              frame_last;
  } patch_word_t;

  // How a directed row gets its expectation: from the predictor, none at all, or typed in.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_WORD
  } row_check_e;

  typedef struct packed {
    logic        obu_mode;
    tile_rec_t   rec;
    row_check_e  check;
    patch_word_t word;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  obu_sba_tile_if  tile_if ();
  obu_sba_patch_if patch_if ();

  obu_size_back_annotator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tile_i      (tile_if),
    .patch_o     (patch_if)
  );

  // Predictor copy of the registers and of the frame state.
  logic              reg_enable;
  logic              reg_obu_mode;
  logic              frm_open;
  logic              frm_muted;
  logic [WORD_W-1:0] lead_len;
  logic [WORD_W-1:0] lead_dsz;
  logic [WORD_W-1:0] wr_ptr;
  logic [WORD_W-1:0] grp_sum;

  patch_word_t patch_expect_q [$];

  // Expectation mode of the record now on the tile channel, driven along with it.
  row_check_e  pend_check;
  patch_word_t pend_word;

  bit          idle_on;
  int unsigned sink_hold = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Directed rows: single-tile frames, zero-length tiles with and without frame end, muted
  // records, multi-tile groups, the widest sizes, a frame end that closes no group, a frame
  // that opens on a non-first tile, a group restarted before its end, then frame OBU mode.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, '{32'd100, 32'd80, 4'd0, 1'b1, 1'b1, 1'b1, 32'd0},
      CHK_WORD, '{ST_WRITTEN, 32'd16, 32'h0080_80D0, 1'b1}},
    '{1'b0, '{32'd0, 32'd0, 4'd0, 1'b1, 1'b0, 1'b0, 32'd0},
      CHK_WORD, '{ST_INCOMPLETE, 32'd0, 32'd0, 1'b1}},
    '{1'b0, '{32'd500, 32'd400, 4'd3, 1'b1, 1'b1, 1'b0, 32'd0}, CHK_NONE, '0},
    '{1'b0, '{32'd20, 32'd10, 4'd0, 1'b0, 1'b1, 1'b1, 32'd0}, CHK_NONE, '0},
    '{1'b0, '{32'd200, 32'd150, 4'd2, 1'b1, 1'b0, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b0, '{32'd300, 32'd290, 4'd2, 1'b0, 1'b0, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b0, '{32'd50, 32'd40, 4'd2, 1'b0, 1'b1, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b0, '{32'd0, 32'd0, 4'd0, 1'b1, 1'b1, 1'b1, 32'd0},
      CHK_WORD, '{ST_INCOMPLETE, 32'd0, 32'd0, 1'b1}},
    '{1'b0, '{32'hFFFF_FFFF, 32'd0, 4'd15, 1'b1, 1'b1, 1'b1, 32'd0}, CHK_MODEL, '0},
    '{1'b0, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF},
      CHK_MODEL, '0},
    '{1'b0, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF},
      CHK_MODEL, '0},
    '{1'b0, '{32'd64, 32'd60, 4'd1, 1'b1, 1'b0, 1'b1, 32'd0}, CHK_NONE, '0},
    '{1'b0, '{32'd40, 32'd30, 4'd0, 1'b0, 1'b0, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b0, '{32'd70, 32'd60, 4'd5, 1'b1, 1'b0, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b0, '{32'd80, 32'd75, 4'd5, 1'b1, 1'b1, 1'b1, 32'd0}, CHK_MODEL, '0},
    '{1'b1, '{32'd120, 32'd90, 4'd0, 1'b1, 1'b1, 1'b1, 32'h0000_0040}, CHK_MODEL, '0},
    '{1'b1, '{32'd400, 32'd300, 4'd6, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF}, CHK_MODEL, '0},
    '{1'b1, '{32'd250, 32'd240, 4'd6, 1'b0, 1'b0, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b1, '{32'd30, 32'd20, 4'd6, 1'b0, 1'b1, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b1, '{32'd90, 32'd80, 4'd0, 1'b1, 1'b1, 1'b0, 32'd0}, CHK_MODEL, '0},
    '{1'b1, '{32'd0, 32'd5, 4'd9, 1'b1, 1'b1, 1'b1, 32'd0},
      CHK_WORD, '{ST_INCOMPLETE, 32'd0, 32'd0, 1'b1}},
    '{1'b1, '{32'd60, 32'd50, 4'd3, 1'b0, 1'b1, 1'b1, 32'd12345}, CHK_MODEL, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Fixed four-byte LEB128: seven payload bits per byte, continuation on the lower three,
  // payload bits 28 and up fall off the end.
  function automatic logic [WORD_W-1:0] leb4_word(input logic [WORD_W-1:0] v);
    return {1'b0, v[27:21], 1'b1, v[20:14], 1'b1, v[13:7], 1'b1, v[6:0]};
  endfunction

  function automatic void close_frame();
    frm_open  = 1'b0;
    frm_muted = 1'b0;
    grp_sum   = '0;
    wr_ptr    = '0;
  endfunction

  // Advance the predicted frame state by one accepted record; return 1 with the word it
  // should produce, if any.
  function automatic bit annotate_tile(input tile_rec_t t, output patch_word_t w);
    logic [WORD_W-1:0] coded;
    logic [WORD_W-1:0] payload;
    logic [WORD_W-1:0] hdr;
    w = '0;
    annotate_tile = 1'b0;
    // Disabled: drop the record, touch nothing.
    if (!reg_enable) return 1'b0;
    // Muted after a zero-length tile: only the frame end matters.
    if (frm_muted) begin
      if (t.frm_last) close_frame();
      return 1'b0;
    end
    // Frame opener: latch its sizes and place the first size field.
    if (!frm_open) begin
      lead_len = t.tile_length;
      lead_dsz = t.tile_data_size;
      if (reg_obu_mode) begin
        wr_ptr = t.frame_hdr_offset;
      end else begin
        wr_ptr = t.tile_length - t.tile_data_size - 32'(t.gsb) - 32'(SIZE_FIELD_BYTES);
        if (t.gsb != 0 && !(t.grp_first && t.grp_last)) begin
          wr_ptr -= 32'(TILE_SIZE_FIELD_BYTES);
        end
      end
      frm_open = 1'b1;
    end
    // Zero-length tile: flag the frame incomplete and mute the rest of it.
    if (t.tile_length == '0) begin
      w.status     = ST_INCOMPLETE;
      w.frame_last = 1'b1;
      if (t.frm_last) close_frame();
      else frm_muted = 1'b1;
      return 1'b1;
    end
    // A group opener restarts the sum, dropping any unfinished group.
    if (t.grp_first) begin
      grp_sum = t.tile_data_size + 32'(t.gsb)
                + (t.grp_last ? 32'd0 : 32'(TILE_SIZE_FIELD_BYTES));
    end else begin
      grp_sum += t.tile_length;
    end
    if (t.grp_last) begin
      coded   = grp_sum;
      payload = coded;
      // Frame OBU layout: the frame header rides in every group's size.
      if (reg_obu_mode) begin
        hdr = lead_len - lead_dsz - wr_ptr - 32'(SIZE_FIELD_BYTES) - 32'd1 - 32'(t.gsb);
        if (t.gsb != 0 && !t.grp_first) hdr -= 32'(TILE_SIZE_FIELD_BYTES);
        payload += hdr + 32'd1;
      end
      w.status       = ST_WRITTEN;
      w.write_offset = wr_ptr;
      w.size_field   = leb4_word(payload);
      w.frame_last   = t.frm_last;
      annotate_tile  = 1'b1;
      // Step past this group: its payload, the OBU header byte and the size field.
      wr_ptr  += coded + 32'd1 + 32'(SIZE_FIELD_BYTES);
      grp_sum  = '0;
    end
    if (t.frm_last) close_frame();
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Present one record and hold it until the block takes it; insert an idle burst now and
  // then.
  task automatic drive_tile(input tile_rec_t rec, input row_check_e chk,
                            input patch_word_t word);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      tile_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    tile_if.valid                  <= 1'b1;
    tile_if.tile_length            <= rec.tile_length;
    tile_if.tile_data_size         <= rec.tile_data_size;
    tile_if.group_size_field_bytes <= rec.gsb;
    tile_if.first_in_group         <= rec.grp_first;
    tile_if.last_in_group          <= rec.grp_last;
    tile_if.last_in_frame          <= rec.frm_last;
    tile_if.frame_hdr_offset       <= rec.frame_hdr_offset;
    pend_check                     <= chk;
    pend_word                      <= word;
    do @(posedge clk_i); while (!tile_if.ready);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline go quiet. Let the clock tick
  // first so the last accepted record has been predicted.
  task automatic drain_words();
    tile_if.valid <= 1'b0;
    @(posedge clk_i);
    while (patch_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; the predictor follows once they have landed.
  task automatic set_regs(input logic en, input logic obu_mode);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ENABLE;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FRAME_OBU;
    cfg_wdata_i <= obu_mode;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    reg_enable   = en;
    reg_obu_mode = obu_mode;
  endtask

  // Mostly well-formed frames of one to four groups, each of one to four tiles, with random
  // sizes and the odd zero-length tile; the rest are records with random flags that break
  // frames apart.
  task automatic send_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned n_grp;
    int unsigned n_tile;
    logic [GSB_W-1:0] gsb;
    tile_rec_t rec;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        rec.tile_length      = ($urandom_range(0, 7) == 0) ? '0 : WORD_W'($urandom);
        rec.tile_data_size   = $urandom;
        rec.gsb              = GSB_W'($urandom);
        rec.grp_first        = 1'($urandom);
        rec.grp_last         = 1'($urandom);
        rec.frm_last         = 1'($urandom);
        rec.frame_hdr_offset = $urandom;
        drive_tile(rec, CHK_MODEL, '0);
        sent++;
      end else begin
        n_grp = $urandom_range(1, 4);
        for (int g = 0; g < n_grp; g++) begin
          gsb    = ($urandom_range(0, 2) == 0) ? '0 : GSB_W'($urandom_range(1, 15));
          n_tile = $urandom_range(1, 4);
          for (int k = 0; k < n_tile; k++) begin
            case ($urandom_range(0, 9))
              0:       rec.tile_data_size = $urandom;
              1, 2:    rec.tile_data_size = $urandom_range(0, 32'h00FF_FFFF);
              default: rec.tile_data_size = $urandom_range(0, 4000);
            endcase
            rec.tile_length = rec.tile_data_size + $urandom_range(0, 40);
            case ($urandom_range(0, 59))
              0:       rec.tile_length = '0;
              1, 2:    rec.tile_length = $urandom;
              default: ;
            endcase
            rec.gsb              = gsb;
            rec.grp_first        = (k == 0);
            rec.grp_last         = (k == n_tile - 1);
            rec.frm_last         = rec.grp_last && (g == n_grp - 1);
            rec.frame_hdr_offset = $urandom;
            drive_tile(rec, CHK_MODEL, '0);
            sent++;
          end
        end
      end
    end
  endtask

  task automatic run_phase(input logic en, input logic obu_mode, input int unsigned n_items,
                           input bit idle);
    drain_words();
    set_regs(en, obu_mode);
    idle_on = idle;
    send_frames(n_items);
  endtask

  // Sink side: stall the patch channel in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
      patch_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(0, 4);
      patch_if.ready <= 1'b0;
    end else begin
      patch_if.ready <= 1'b1;
    end
  end

  // Predict on each accepted record, then check each accepted patch word; handle both in
  // one block so a same-edge pair resolves in a fixed order.
  always @(posedge clk_i) begin : check_words
    tile_rec_t   rec;
    patch_word_t word;
    patch_word_t want;
    if (rst_ni) begin
      if (tile_if.valid && tile_if.ready) begin
        rec.tile_length      = tile_if.tile_length;
        rec.tile_data_size   = tile_if.tile_data_size;
        rec.gsb              = tile_if.group_size_field_bytes;
        rec.grp_first        = tile_if.first_in_group;
        rec.grp_last         = tile_if.last_in_group;
        rec.frm_last         = tile_if.last_in_frame;
        rec.frame_hdr_offset = tile_if.frame_hdr_offset;
        // Always advance the predictor, even where the row pins its own answer.
        if (annotate_tile(rec, word) && pend_check == CHK_MODEL) begin
          patch_expect_q.push_back(word);
        end
        if (pend_check == CHK_WORD) patch_expect_q.push_back(pend_word);
      end
      if (patch_if.valid && patch_if.ready) begin
        if (patch_expect_q.size() == 0) begin
          report_mismatch("unexpected word, offset", patch_if.write_offset, '0);
        end else begin
          want = patch_expect_q.pop_front();
          if (patch_if.status !== want.status) begin
            report_mismatch("status", 32'(patch_if.status), 32'(want.status));
          end
          if (patch_if.write_offset !== want.write_offset) begin
            report_mismatch("write_offset", patch_if.write_offset, want.write_offset);
          end
          if (patch_if.size_field !== want.size_field) begin
            report_mismatch("size_field", patch_if.size_field, want.size_field);
          end
          if (patch_if.frame_last !== want.frame_last) begin
            report_mismatch("frame_last", 32'(patch_if.frame_last), 32'(want.frame_last));
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni                         <= 1'b0;
    cfg_we_i                       <= 1'b0;
    cfg_idx_i                      <= CFG_ENABLE;
    cfg_wdata_i                    <= '0;
    tile_if.valid                  <= 1'b0;
    tile_if.tile_length            <= '0;
    tile_if.tile_data_size         <= '0;
    tile_if.group_size_field_bytes <= '0;
    tile_if.first_in_group         <= 1'b0;
    tile_if.last_in_group          <= 1'b0;
    tile_if.last_in_frame          <= 1'b0;
    tile_if.frame_hdr_offset       <= '0;
    pend_check                     <= CHK_MODEL;
    pend_word                      <= '0;
    reg_enable   = 1'b0;
    reg_obu_mode = 1'b0;
    lead_len     = '0;
    lead_dsz     = '0;
    close_frame();
    idle_on    = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; switch the layout only once the block has gone quiet.
    set_regs(1'b1, 1'b0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].obu_mode != reg_obu_mode) begin
        drain_words();
        set_regs(1'b1, directed_rows[i].obu_mode);
      end
      drive_tile(directed_rows[i].rec, directed_rows[i].check, directed_rows[i].word);
    end

    // Random phases across both layouts, a disabled stretch, and runs without idling;
    // the last one keeps both sides busy.
    run_phase(1'b1, 1'b0, 600, 1'b1);
    run_phase(1'b1, 1'b1, 600, 1'b1);
    run_phase(1'b0, 1'b1, 40, 1'b1);
    run_phase(1'b1, 1'b1, 300, 1'b0);
    run_phase(1'b1, 1'b0, 400, 1'b1);
    run_phase(1'b1, 1'b1, 150, 1'b0);
    drain_words();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
